[hdl/fgrc_pkg.sv]
// Package for the fuel gauge reading conditioner: field widths, register
// indexes, status codes and divider constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fgrc_pkg;

  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  localparam int UV_W    = 23;
  localparam int RAW_W   = 15;
  localparam int PCT_W   = 7;
  localparam int STAT_W  = 3;
  localparam int DIV_W   = 14;
  localparam int DVD_W   = 28;
  localparam int THR_W   = 7;
  localparam int ZCNT_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE_DIVISOR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_THRESHOLD       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_CONFIRM_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARGER_INFO_PRESENT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_INFO_PRESENT = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_UNKNOWN      = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_CHARGING     = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_CHARGING = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_DISCHARGING  = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_FULL         = 3'd4;

  localparam logic [DIV_W-1:0]  DIVISOR_RESET   = 14'd9300;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 7'd95;
  localparam logic [ZCNT_W-1:0] ZCOUNT_RESET    = 4'd3;

  localparam int UV_PER_CODE = 1250;
  localparam int SCALE_NUM   = 10000;
  localparam int PCT_CAP     = 100;
  localparam int ROUND_HALF  = 50;
  // (adj + 50) / 100 reaches the cap at adj = 9950
  localparam int CAP_ADJ     = PCT_CAP * 100 - ROUND_HALF;
  // floor(x / 100) = (x * 5243) >> 19 for x below 10000
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 27;

  localparam logic [4:0] DIV_LAST = 5'(DVD_W - 1);

endpackage

`default_nettype wire

[hdl/fuel_gauge_reading_conditioner.sv]
// Fuel gauge reading conditioner: converts one raw gauge reading into
// voltage, raw and conditioned charge, online flag and charge status.
// Depends on fgrc_pkg.
//
// Each request runs to completion before the next is taken. The reading is
// registered at the accepting edge. It then passes through ST_RAW (voltage
// and raw charge), ST_PREP (28-bit scaled dividend), ST_DIV (28 steps of a
// restoring bit-serial divider by full_scale_divisor), ST_SCALE (round and
// cap) and ST_FIN (filter and set status; waits while the output register
// holds an untaken result). The next request is accepted only after the
// result is registered. The divider sets the rate; in_tready is high only
// while no request is in work, and a result waiting in the output register
// does not block the next request until that one finishes. Configuration
// writes take effect at once and are expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module fuel_gauge_reading_conditioner (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // charge_high_byte, charge_low_byte, voltage_high_byte, voltage_low_byte
  input  wire logic [fgrc_pkg::IN_DATA_W-1:0]      in_tdata,
  // charger_connected, charging_enabled, battery_present
  input  wire logic [fgrc_pkg::IN_USER_W-1:0]      in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // cell_microvolts, raw_charge_hundredths, charge_percent, zero fill
  output logic [fgrc_pkg::OUT_DATA_W-1:0]          out_tdata,
  // online, charge_status
  output logic [fgrc_pkg::OUT_USER_W-1:0]          out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [fgrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [fgrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import fgrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_PREP,
    ST_DIV,
    ST_SCALE,
    ST_FIN
  } state_t;

  state_t              state_r, state_nxt;

  logic [DIV_W-1:0]    divisor_r, divisor_nxt;
  logic [THR_W-1:0]    threshold_r, threshold_nxt;
  logic [ZCNT_W-1:0]   zcount_r, zcount_nxt;
  logic                chg_info_r, chg_info_nxt;
  logic                bat_info_r, bat_info_nxt;

  logic [PCT_W-1:0]    last_pct_r, last_pct_nxt;
  logic [ZCNT_W-1:0]   zero_run_r, zero_run_nxt;

  logic [IN_DATA_W-1:0] in_data_r, in_data_nxt;
  logic [IN_USER_W-1:0] in_user_r, in_user_nxt;
  logic [UV_W-1:0]     uv_r, uv_nxt;
  logic [RAW_W-1:0]    raw_r, raw_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [PCT_W-1:0]    pct_r, pct_nxt;

  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [DIV_W-1:0]    div_eff;
  logic [DIV_W:0]      trial;
  logic                trial_ge;
  logic [DIV_W:0]      trial_diff;
  logic [11:0]         volt_code;
  logic [15:0]         low_frac;
  logic [DIV_W-1:0]    round_x;
  logic [PROD_W-1:0]   round_prod;
  logic [ZCNT_W-1:0]   zr_inc;
  logic [PCT_W-1:0]    pct_fin;
  logic [ZCNT_W-1:0]   zr_fin;
  logic                online;
  logic [STAT_W-1:0]   status;
  logic                out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    div_eff    = (divisor_r == '0) ? DIV_W'(1) : divisor_r;
    trial      = {rem_r, dvd_r[DVD_W-1]};
    trial_ge   = (trial >= {1'b0, div_eff});
    trial_diff = trial - {1'b0, div_eff};
    volt_code  = {in_data_r[23:16], in_data_r[31:28]};
    low_frac   = 16'(in_data_r[15:8]) * 16'(100);
    round_x    = dvd_r[DIV_W-1:0] + DIV_W'(ROUND_HALF);
    round_prod = PROD_W'(round_x) * PROD_W'(RECIP_100);
    zr_inc     = zero_run_r + 4'd1;

    if (pct_r == '0) begin
      if (zr_inc >= zcount_r) begin
        pct_fin = '0;
        zr_fin  = '0;
      end else begin
        pct_fin = last_pct_r;
        zr_fin  = zr_inc;
      end
    end else begin
      pct_fin = pct_r;
      zr_fin  = '0;
    end

    online = bat_info_r ? in_user_r[2] : 1'b1;

    if (!chg_info_r) begin
      status = STATUS_UNKNOWN;
    end else if (pct_fin > threshold_r) begin
      status = STATUS_FULL;
    end else if (in_user_r[0]) begin
      status = in_user_r[1] ? STATUS_CHARGING : STATUS_NOT_CHARGING;
    end else begin
      status = STATUS_DISCHARGING;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    divisor_nxt   = divisor_r;
    threshold_nxt = threshold_r;
    zcount_nxt    = zcount_r;
    chg_info_nxt  = chg_info_r;
    bat_info_nxt  = bat_info_r;
    last_pct_nxt  = last_pct_r;
    zero_run_nxt  = zero_run_r;
    in_data_nxt   = in_data_r;
    in_user_nxt   = in_user_r;
    uv_nxt        = uv_r;
    raw_nxt       = raw_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    pct_nxt       = pct_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FULL_SCALE_DIVISOR:   divisor_nxt   = cfg_data[DIV_W-1:0];
        REG_FULL_THRESHOLD:       threshold_nxt = cfg_data[THR_W-1:0];
        REG_ZERO_CONFIRM_COUNT:   zcount_nxt    = cfg_data[ZCNT_W-1:0];
        REG_CHARGER_INFO_PRESENT: chg_info_nxt  = cfg_data[0];
        REG_BATTERY_INFO_PRESENT: bat_info_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          in_data_nxt = in_tdata;
          in_user_nxt = in_tuser;
          state_nxt   = ST_RAW;
        end
      end
      ST_RAW: begin
        uv_nxt    = UV_W'(volt_code) * UV_W'(UV_PER_CODE);
        raw_nxt   = RAW_W'(in_data_r[7:0]) * RAW_W'(100) + RAW_W'(low_frac[15:8]);
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        dvd_nxt   = DVD_W'(raw_r) * DVD_W'(SCALE_NUM);
        rem_nxt   = '0;
        cnt_nxt   = DIV_LAST;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], trial_ge};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (dvd_r >= DVD_W'(CAP_ADJ)) begin
          pct_nxt = PCT_W'(PCT_CAP);
        end else begin
          pct_nxt = round_prod[RECIP_SHIFT +: PCT_W];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          last_pct_nxt  = pct_fin;
          zero_run_nxt  = zr_fin;
          out_data_nxt  = {3'b000, pct_fin, raw_r, uv_r};
          out_user_nxt  = {status, online};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      divisor_r   <= DIVISOR_RESET;
      threshold_r <= THRESHOLD_RESET;
      zcount_r    <= ZCOUNT_RESET;
      chg_info_r  <= 1'b1;
      bat_info_r  <= 1'b1;
      last_pct_r  <= '0;
      zero_run_r  <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      divisor_r   <= divisor_nxt;
      threshold_r <= threshold_nxt;
      zcount_r    <= zcount_nxt;
      chg_info_r  <= chg_info_nxt;
      bat_info_r  <= bat_info_nxt;
      last_pct_r  <= last_pct_nxt;
      zero_run_r  <= zero_run_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_data_r  <= in_data_nxt;
    in_user_r  <= in_user_nxt;
    uv_r       <= uv_nxt;
    raw_r      <= raw_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    pct_r      <= pct_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

`default_nettype wire
